[sv/sync_length_frame_deframer_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the deframer RTL
// Clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define SYNC_LENGTH_FRAME_DEFRAMER_CORE_ASSERT_SVH

// Check that cons holds in the same cycle as ante
`define SLFD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante
`define SLFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[sv/slfd_pkg.sv]
// ----------------------------------------------------------------------------
// slfd_pkg
// Shared types and constants of the sync/length frame deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package slfd_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    // Largest payload the downstream buffer takes
    localparam int MAX_PAYLOAD = 64;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN     = 2'd3;

    // Register reset values
    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'd0;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'd0;
    localparam logic [LEN_W-1:0]  MIN_LEN_RST     = 7'd6;
    localparam logic [LEN_W-1:0]  MAX_LEN_RST     = 7'd46;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
        logic [LEN_W-1:0]  min_len;
        logic [LEN_W-1:0]  max_len;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic [LEN_W-1:0]  frame_len;
        logic              last;
    } t_result;

    typedef enum logic [3:0] {
        PH_HUNT  = 4'b0001,
        PH_SYNC2 = 4'b0010,
        PH_LEN   = 4'b0100,
        PH_DATA  = 4'b1000
    } t_phase;

endpackage

[sv/slfd_parser.sv]
// ----------------------------------------------------------------------------
// slfd_parser
// Header state machine and payload counter; one byte per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sync_length_frame_deframer_core_assert.svh"

module slfd_parser #(
    parameter int MAX_PAYLOAD = slfd_pkg::MAX_PAYLOAD
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  slfd_pkg::t_cfg                 i_cfg,
    input  logic                           i_step,
    input  logic [slfd_pkg::BYTE_W-1:0]    i_byte,
    output logic                           o_emit,
    output slfd_pkg::t_result              o_res
);

    // Length cap: buffer depth, limited to what the length field can carry
    localparam int LEN_CAP_INT = (MAX_PAYLOAD > 127) ? 127 : MAX_PAYLOAD;
    localparam logic [slfd_pkg::LEN_W-1:0] LEN_CAP = LEN_CAP_INT[slfd_pkg::LEN_W-1:0];

    slfd_pkg::t_phase                r_phase, n_phase;
    logic [slfd_pkg::LEN_W-1:0]      r_count, n_count;
    logic [slfd_pkg::LEN_W-1:0]      r_expected_len, n_expected_len;

    logic                            w_len_ok;
    logic [slfd_pkg::LEN_W-1:0]      w_count_inc;
    logic                            w_fin;

    // Length byte check against the configured window and the buffer cap; zero is always rejected
    assign w_len_ok = (i_byte != '0)
                   && (i_byte >= {1'b0, i_cfg.min_len})
                   && (i_byte <= {1'b0, i_cfg.max_len})
                   && (i_byte <= {1'b0, LEN_CAP});

    // Advance the payload count; final byte when it reaches the length
    assign w_count_inc = r_count + 7'd1;
    assign w_fin       = (w_count_inc >= r_expected_len);

    // Next state
    always_comb begin
        n_phase        = r_phase;
        n_count        = r_count;
        n_expected_len = r_expected_len;
        o_emit         = 1'b0;
        case (r_phase)
            slfd_pkg::PH_HUNT: begin
                if (i_byte == i_cfg.sync_first) n_phase = slfd_pkg::PH_SYNC2;
            end
            slfd_pkg::PH_SYNC2: begin
                // Second sync wins when both sync values are equal
                if (i_byte == i_cfg.sync_second) begin
                    n_phase = slfd_pkg::PH_LEN;
                end else if (i_byte == i_cfg.sync_first) begin
                    n_phase = slfd_pkg::PH_SYNC2;
                end else begin
                    n_phase = slfd_pkg::PH_HUNT;
                end
            end
            slfd_pkg::PH_LEN: begin
                if (w_len_ok) begin
                    n_expected_len = i_byte[slfd_pkg::LEN_W-1:0];
                    n_count        = '0;
                    n_phase        = slfd_pkg::PH_DATA;
                end else begin
                    n_phase = slfd_pkg::PH_HUNT;
                end
            end
            slfd_pkg::PH_DATA: begin
                o_emit  = 1'b1;
                n_count = w_count_inc;
                if (w_fin) begin
                    n_phase = slfd_pkg::PH_HUNT;
                    n_count = '0;
                end
            end
            default: begin
                n_phase = slfd_pkg::PH_HUNT;
            end
        endcase
    end

    assign o_res.payload_byte = i_byte;
    assign o_res.frame_len    = r_expected_len;
    assign o_res.last         = w_fin;

    // State registers, updated only on a step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= slfd_pkg::PH_HUNT;
            r_count        <= '0;
            r_expected_len <= '0;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_count        <= n_count;
            r_expected_len <= n_expected_len;
        end
    end

    `SLFD_ASSERT_SAME(a_count_below_len, r_phase == slfd_pkg::PH_DATA,
        r_count < r_expected_len, "payload count reached frame length in payload phase")
    `SLFD_ASSERT_SAME(a_len_in_cap, r_phase == slfd_pkg::PH_DATA,
        (r_expected_len != '0) && (r_expected_len <= LEN_CAP),
        "frame length outside buffer cap")
    `SLFD_ASSERT_NEXT(a_last_to_hunt, i_step && o_emit && o_res.last,
        r_phase == slfd_pkg::PH_HUNT, "no return to hunting after last byte")

endmodule

[sv/sync_length_frame_deframer_core.sv]
// ----------------------------------------------------------------------------
// sync_length_frame_deframer_core
// Recovers sync/sync/length/payload frames from a received byte stream.
// ----------------------------------------------------------------------------
// Takes one byte per cycle, sustained: a byte is accepted every cycle while
// the result side keeps up. Each byte is registered on input and run through
// the header state machine and payload counter when it advances out of the
// input register; a payload byte is then loaded into the result register, so
// a result passes through the input register and then the result register.
// Header and rejected bytes give no result. Only a stalled result register
// holds off the input side. Register writes take effect at the next edge and
// should be made while no transaction is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sync_length_frame_deframer_core_assert.svh"

module sync_length_frame_deframer_core #(
    parameter int MAX_PAYLOAD = slfd_pkg::MAX_PAYLOAD
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration
    input  logic                               i_cfg_we,
    input  logic [slfd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [slfd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Byte input
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [slfd_pkg::BYTE_W-1:0]        i_rx_byte,
    // Payload output
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [slfd_pkg::BYTE_W-1:0]        o_payload_byte,
    output logic [slfd_pkg::LEN_W-1:0]         o_frame_len,
    output logic                               o_last
);

    slfd_pkg::t_cfg                  r_cfg;
    logic                            r_in_valid;
    logic [slfd_pkg::BYTE_W-1:0]     r_in_byte;
    logic                            r_out_valid;
    slfd_pkg::t_result               r_out;

    logic                            w_in_fire;
    logic                            w_adv;
    logic                            w_emit;
    slfd_pkg::t_result               w_res;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first  <= slfd_pkg::SYNC_FIRST_RST;
            r_cfg.sync_second <= slfd_pkg::SYNC_SECOND_RST;
            r_cfg.min_len     <= slfd_pkg::MIN_LEN_RST;
            r_cfg.max_len     <= slfd_pkg::MAX_LEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                slfd_pkg::CFG_SYNC_FIRST:  r_cfg.sync_first  <= i_cfg_data;
                slfd_pkg::CFG_SYNC_SECOND: r_cfg.sync_second <= i_cfg_data;
                slfd_pkg::CFG_MIN_LEN:     r_cfg.min_len <= i_cfg_data[slfd_pkg::LEN_W-1:0];
                slfd_pkg::CFG_MAX_LEN:     r_cfg.max_len <= i_cfg_data[slfd_pkg::LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Advance the staged byte when the result register is free or draining
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;
    assign w_in_fire  = i_in_valid && o_in_ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in_byte <= i_rx_byte;
        end
    end

    slfd_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_step  (w_adv),
        .i_byte  (r_in_byte),
        .o_emit  (w_emit),
        .o_res   (w_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_emit) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_payload_byte = r_out.payload_byte;
    assign o_frame_len    = r_out.frame_len;
    assign o_last         = r_out.last;

    `SLFD_ASSERT_NEXT(a_in_hold, r_in_valid && !w_adv,
        r_in_valid && $stable(r_in_byte), "staged byte lost while stalled")
    `SLFD_ASSERT_SAME(a_no_overwrite, w_adv && w_emit && r_out_valid,
        i_out_ready, "result register overwritten before it was taken")

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench of the sync/length frame deframer
// Drives received bytes through the valid/ready input and tracks header
// hunting, length checks and the payload count in a local frame model. Each
// payload transaction is compared against the oldest expected byte. Directed
// header and length cases run first, then random frame traffic under several
// register settings and three source/sink idle mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int ITEMS_PER_SEG  = 284;
    localparam int NUM_SEGMENTS   = 6;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [slfd_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [slfd_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                            i_in_valid;
    logic                            o_in_ready;
    logic [slfd_pkg::BYTE_W-1:0]     i_rx_byte;
    logic                            o_out_valid;
    logic                            i_out_ready;
    logic [slfd_pkg::BYTE_W-1:0]     o_payload_byte;
    logic [slfd_pkg::LEN_W-1:0]      o_frame_len;
    logic                            o_last;

    // Frame model: register copy, header phase and payload counter
    slfd_pkg::t_cfg             dev_cfg = '{slfd_pkg::SYNC_FIRST_RST,
                                            slfd_pkg::SYNC_SECOND_RST,
                                            slfd_pkg::MIN_LEN_RST,
                                            slfd_pkg::MAX_LEN_RST};
    slfd_pkg::t_phase           frame_ph = slfd_pkg::PH_HUNT;
    logic [slfd_pkg::LEN_W-1:0] data_count = '0;
    logic [slfd_pkg::LEN_W-1:0] accepted_len = '0;
    slfd_pkg::t_result          payload_q[$];

    int fail_count = 0;
    int cycle_count = 0;
    int src_idle_pct = 0;
    int sink_idle_pct = 0;

    sync_length_frame_deframer_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_payload_byte (o_payload_byte),
        .o_frame_len    (o_frame_len),
        .o_last         (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Length accepted only inside [min_len, max_len], never zero, never past the buffer
    function automatic bit length_fits(input logic [slfd_pkg::BYTE_W-1:0] len);
        int cap;
        cap = dev_cfg.max_len;
        if (cap > slfd_pkg::MAX_PAYLOAD) cap = slfd_pkg::MAX_PAYLOAD;
        if (cap > 127) cap = 127;
        return (len != 0) && (int'(len) >= int'(dev_cfg.min_len)) && (int'(len) <= cap);
    endfunction

    // Advance the frame model by one received byte; queue a payload byte if one results
    function automatic void deframe_byte(input logic [slfd_pkg::BYTE_W-1:0] b);
        slfd_pkg::t_result r;
        case (frame_ph)
            slfd_pkg::PH_HUNT: begin
                if (b == dev_cfg.sync_first) frame_ph = slfd_pkg::PH_SYNC2;
            end
            slfd_pkg::PH_SYNC2: begin
                // second sync is tested first so equal sync values pair up
                if (b == dev_cfg.sync_second) frame_ph = slfd_pkg::PH_LEN;
                else if (b == dev_cfg.sync_first) frame_ph = slfd_pkg::PH_SYNC2;
                else frame_ph = slfd_pkg::PH_HUNT;
            end
            slfd_pkg::PH_LEN: begin
                if (length_fits(b)) begin
                    accepted_len = b[slfd_pkg::LEN_W-1:0];
                    data_count = '0;
                    frame_ph = slfd_pkg::PH_DATA;
                end else begin
                    frame_ph = slfd_pkg::PH_HUNT;
                end
            end
            default: begin
                data_count = data_count + 1'b1;
                r.payload_byte = b;
                r.frame_len = accepted_len;
                r.last = (data_count >= accepted_len);
                payload_q.push_back(r);
                if (r.last) begin
                    frame_ph = slfd_pkg::PH_HUNT;
                    data_count = '0;
                end
            end
        endcase
    endfunction

    // Check each payload transaction, then model each accepted input byte
    always @(posedge i_clk) begin : scoreboard
        slfd_pkg::t_result want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (payload_q.size() == 0) begin
                    $display("%0t: unexpected payload transaction, expected none, actual %02h",
                             $time, o_payload_byte);
                    fail_count++;
                end else begin
                    want = payload_q.pop_front();
                    if (o_payload_byte !== want.payload_byte) begin
                        $display("%0t: payload_byte expected %02h actual %02h",
                                 $time, want.payload_byte, o_payload_byte);
                        fail_count++;
                    end
                    if (o_frame_len !== want.frame_len) begin
                        $display("%0t: frame_len expected %0d actual %0d",
                                 $time, want.frame_len, o_frame_len);
                        fail_count++;
                    end
                    if (o_last !== want.last) begin
                        $display("%0t: last expected %0d actual %0d",
                                 $time, want.last, o_last);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) deframe_byte(i_rx_byte);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d payload bytes outstanding", $time, payload_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Sink: stall at random per cycle
    always @(negedge i_clk) begin
        i_out_ready = ($urandom_range(0, 99) >= sink_idle_pct);
    end

    task automatic set_idle(input int src_pct, input int sink_pct);
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
    endtask

    // Present one byte and hold it until the transaction completes
    task automatic send_byte(input logic [slfd_pkg::BYTE_W-1:0] b);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_rx_byte = b;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Drop valid, drain expected payload, then let header bytes in flight settle
    task automatic wait_idle;
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (payload_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [slfd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [slfd_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        case (idx)
            slfd_pkg::CFG_SYNC_FIRST:  dev_cfg.sync_first = data;
            slfd_pkg::CFG_SYNC_SECOND: dev_cfg.sync_second = data;
            slfd_pkg::CFG_MIN_LEN:     dev_cfg.min_len = data[slfd_pkg::LEN_W-1:0];
            slfd_pkg::CFG_MAX_LEN:     dev_cfg.max_len = data[slfd_pkg::LEN_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_config(input logic [7:0] sf, input logic [7:0] ss,
                              input logic [7:0] mn, input logic [7:0] mx);
        wait_idle();
        write_reg(slfd_pkg::CFG_SYNC_FIRST, sf);
        write_reg(slfd_pkg::CFG_SYNC_SECOND, ss);
        write_reg(slfd_pkg::CFG_MIN_LEN, mn);
        write_reg(slfd_pkg::CFG_MAX_LEN, mx);
    endtask

    task automatic send_header(input logic [slfd_pkg::BYTE_W-1:0] len);
        send_byte(dev_cfg.sync_first);
        send_byte(dev_cfg.sync_second);
        send_byte(len);
    endtask

    // Reset registers: both syncs zero, lengths 6..46
    task automatic test_reset_values;
        send_header(8'h05);
        send_header(8'h06);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'h01);
        send_byte(8'hFE);
        wait_idle();
    endtask

    // Hunt drops noise; a failed second sync that is itself a first sync restarts
    task automatic test_header_recovery;
        set_config(8'hA5, 8'h5A, 8'd1, 8'd64);
        send_byte(8'h5A);
        send_byte(8'hA5);
        send_byte(8'h33);
        send_byte(8'hA5);
        send_byte(8'hA5);
        send_byte(8'h5A);
        send_byte(8'h01);
        send_byte(8'hFF);
        wait_idle();
    endtask

    // A rejected length byte is dropped, never reused as a first sync
    task automatic test_length_bounds;
        send_header(8'hA5);
        send_byte(8'h5A);
        send_byte(8'h02);
        send_byte(8'h11);
        send_byte(8'h22);
        send_header(8'd65);
        wait_idle();
    endtask

    // min_len above max_len rejects every length
    task automatic test_min_above_max;
        set_config(8'hA5, 8'h5A, 8'd10, 8'd9);
        send_header(8'd9);
        send_header(8'd10);
        wait_idle();
    endtask

    // Equal sync values pair up; zero min_len still rejects length zero
    task automatic test_equal_sync;
        set_config(8'hFF, 8'hFF, 8'd0, 8'hFF);
        send_header(8'h00);
        send_header(8'hFF);
        send_header(8'h02);
        send_byte(8'h00);
        send_byte(8'hFF);
        wait_idle();
    endtask

    // Register writes inside a frame leave its accepted length alone
    task automatic test_cfg_mid_frame;
        send_header(8'h03);
        send_byte(8'hA0);
        wait_idle();
        write_reg(slfd_pkg::CFG_MAX_LEN, 8'd1);
        write_reg(slfd_pkg::CFG_SYNC_FIRST, 8'h00);
        send_byte(8'h0B);
        send_byte(8'hFF);
        wait_idle();
    endtask

    // One random sequence: mostly good frames, some noise and broken headers
    task automatic send_random_sequence(output int n);
        int lo, hi, len, pick, k;
        logic [slfd_pkg::BYTE_W-1:0] b;
        lo = (dev_cfg.min_len == 0) ? 1 : dev_cfg.min_len;
        hi = (dev_cfg.max_len > slfd_pkg::MAX_PAYLOAD) ? slfd_pkg::MAX_PAYLOAD
                                                       : dev_cfg.max_len;
        pick = $urandom_range(0, 99);
        n = 0;
        if (pick < 72 && lo <= hi) begin
            k = $urandom_range(0, 99);
            if (k < 15) len = lo;
            else if (k < 30) len = hi;
            else len = $urandom_range(lo, (hi < lo + 15) ? hi : lo + 15);
            send_header(len[slfd_pkg::BYTE_W-1:0]);
            for (k = 0; k < len; k++) begin
                if ($urandom_range(0, 9) == 0) send_byte(dev_cfg.sync_first);
                else send_byte($urandom_range(0, 255));
            end
            n = len + 3;
        end else if (pick < 82) begin
            // line noise, ignored by the count
            repeat ($urandom_range(1, 4)) send_byte($urandom_range(0, 255));
        end else if (pick < 90) begin
            b = $urandom_range(0, 255);
            if (b == dev_cfg.sync_second) b = ~b;
            send_byte(dev_cfg.sync_first);
            send_byte(b);
            n = 2;
        end else begin
            case ($urandom_range(0, 3))
                0:       len = 0;
                1:       len = hi + 1;
                2:       len = lo - 1;
                default: len = $urandom_range(65, 255);
            endcase
            send_header(len[slfd_pkg::BYTE_W-1:0]);
            n = 3;
        end
    endtask

    task automatic test_random_traffic;
        int seg, seg_items, n;
        logic [7:0] s, mn;
        for (seg = 0; seg < NUM_SEGMENTS; seg++) begin
            case (seg / 2)
                0:       set_idle(26, 66);
                1:       set_idle(66, 26);
                default: set_idle(0, 0);
            endcase
            s = $urandom_range(0, 255);
            mn = $urandom_range(1, 16);
            case (seg)
                0: set_config(8'h00, 8'hFF, 8'd1, 8'd64);
                1: set_config(8'hFF, 8'h00, 8'd64, 8'd64);
                2: set_config(s, $urandom_range(0, 255), mn, $urandom_range(mn, 64));
                3: set_config(8'h55, 8'hAA, 8'd1, 8'd1);
                4: set_config(s, s, $urandom_range(1, 8), $urandom_range(64, 127));
                // bit 7 of the length registers is set and must be ignored
                default: set_config(s, $urandom_range(0, 255), mn | 8'h80,
                                    8'h80 | $urandom_range(mn, 64));
            endcase
            seg_items = 0;
            while (seg_items < ITEMS_PER_SEG) begin
                send_random_sequence(n);
                seg_items += n;
            end
        end
        wait_idle();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = slfd_pkg::CFG_SYNC_FIRST;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_rx_byte = '0;
        i_out_ready = 1'b0;
        set_idle(26, 66);
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (2) @(negedge i_clk);

        test_reset_values();
        test_header_recovery();
        test_length_bounds();
        test_min_above_max();
        test_equal_sync();
        test_cfg_mid_frame();
        test_random_traffic();

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
